### src/rfsr_pkg.sv
// rfsr_pkg: shared types and constants for the range following speed regulator
// holds the sequencer states, configuration register indexes and field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfsr_pkg;

  localparam int unsigned DistW  = 16;
  localparam int unsigned SpeedW = 14;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 13;
  localparam int unsigned ScaleW = 20;
  localparam int unsigned HgtW   = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned ProdW    = 33;
  localparam int unsigned CntW     = 5;

  // divider runs one quotient bit per cycle, multiplier two gain bits per cycle
  localparam logic [CntW-1:0] DivLast = CntW'(ScaleW - 1);
  localparam logic [CntW-1:0] MulLast = CntW'(GainW / 2 - 1);

  typedef enum logic [2:0] {
    REG_BASE_SPEED  = 3'd0,
    REG_SPEED_GAIN  = 3'd1,
    REG_SPEED_LIMIT = 3'd2,
    REG_JUMP_LIMIT  = 3'd3,
    REG_NEAR_LIMIT  = 3'd4,
    REG_FOUND_SCALE = 3'd5,
    REG_LOST_SCALE  = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_PREP = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

### src/range_following_speed_regulator.sv
// range_following_speed_regulator: range estimate and proportional speed command
// bit-serial divider and two-bit-digit serial multiplier; uses rfsr_pkg
//
// channel  dir  signals                         beat contents
// s_axis   in   s_tvalid/s_tready/tdata/tuser   target_distance, pixel_height, marker_found
// m_axis   out  m_tvalid/m_tready/tdata/tuser   speed, range, rejected
// cfg      in   cfg_we/cfg_idx/cfg_wdata        one register write per cycle
//
// each beat goes from accept through the restoring divider (one quotient bit per
// cycle), prepare, the multiplier (two gain bits per cycle) and finish back to
// idle, where the next beat is accepted.
// reset restores register defaults and clears the accepted range and previous speed.
// a finished result waits in the output register; the next beat is taken meanwhile
// and only its finish stalls until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module range_following_speed_regulator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [15:0] target_distance, [27:16] pixel_height, [31:28] zero
  input  wire logic [rfsr_pkg::InDataW-1:0]    s_tdata,
  // [0] marker_found
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [13:0] speed, [29:14] range, [31:30] zero
  output logic [rfsr_pkg::OutDataW-1:0]        m_tdata,
  // [0] rejected
  output logic                                 m_tuser,
  input  wire logic                            cfg_we_i,
  input  wire logic [rfsr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rfsr_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import rfsr_pkg::*;

  // configuration
  logic signed [SpeedW-1:0] base_q;
  logic [GainW-1:0]         gain_q;
  logic [LimW-1:0]          lim_q;
  logic [DistW-1:0]         jump_q;
  logic [DistW-1:0]         near_q;
  logic [ScaleW-1:0]        fscale_q;
  logic [ScaleW-1:0]        lscale_q;

  // sequencer and datapath
  state_e                   st_q, st_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [ScaleW-1:0]        dvd_q, dvd_d;
  logic [HgtW-1:0]          rem_q, rem_d;
  logic [HgtW-1:0]          hgt_q;
  logic [DistW-1:0]         tgt_q;
  logic [DistW-1:0]         range_q, range_d;
  logic signed [ProdW-1:0]  mcand_q, mcand_d;
  logic [GainW-1:0]         mplr_q, mplr_d;
  logic signed [ProdW-1:0]  acc_q, acc_d;

  // state
  logic [DistW-1:0]         accr_q;
  logic signed [SpeedW-1:0] prev_q;

  // output register
  logic                     mval_q;
  logic signed [SpeedW-1:0] mspd_q;
  logic                     mrej_q;
  logic [DistW-1:0]         mrng_q;

  logic                     in_fire;
  logic                     commit;
  logic [HgtW:0]            trial;
  logic                     ge;
  logic [HgtW:0]            trial_sub;
  logic [DistW-1:0]         quo_sat;
  logic signed [DistW:0]    err;
  logic signed [ProdW-1:0]  pp;
  logic signed [23:0]       vel_raw;
  logic signed [23:0]       lim_pos;
  logic signed [23:0]       lim_neg;
  logic signed [SpeedW-1:0] spd_clamp;
  logic signed [SpeedW-1:0] spd_d;
  logic signed [DistW:0]    diff;
  logic                     rej;

  assign s_tready = (st_q == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign commit   = (st_q == S_FIN) && (!mval_q || m_tready);

  assign m_tvalid = mval_q;
  assign m_tdata  = {2'b00, mrng_q, mspd_q};
  assign m_tuser  = mrej_q;

  // restoring division, one quotient bit per cycle
  assign trial     = {rem_q, dvd_q[ScaleW-1]};
  assign ge        = trial >= {1'b0, hgt_q};
  assign trial_sub = trial - {1'b0, hgt_q};

  // a zero height gives an all-ones quotient, which saturates too
  assign quo_sat = (|dvd_q[ScaleW-1:DistW]) ? '1 : dvd_q[DistW-1:0];

  assign err = $signed({1'b0, quo_sat}) - $signed({1'b0, tgt_q});

  // two-bit digit partial product
  always_comb begin
    pp = '0;
    case (mplr_q[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = mcand_q;
      2'd2:    pp = mcand_q <<< 1;
      2'd3:    pp = mcand_q + (mcand_q <<< 1);
      default: pp = '0;
    endcase
  end

  // floor of product / 1024 plus base speed, then clamp
  assign vel_raw = {acc_q[ProdW-1], acc_q[ProdW-1:10]}
                 + {{(24-SpeedW){base_q[SpeedW-1]}}, base_q};
  assign lim_pos = $signed({{(24-LimW){1'b0}}, lim_q});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (vel_raw > lim_pos) begin
      spd_clamp = lim_pos[SpeedW-1:0];
    end else if (vel_raw < lim_neg) begin
      spd_clamp = lim_neg[SpeedW-1:0];
    end else begin
      spd_clamp = vel_raw[SpeedW-1:0];
    end
  end

  assign diff  = $signed({1'b0, range_q}) - $signed({1'b0, accr_q});
  assign rej   = !diff[DistW] && (diff[DistW-1:0] >= jump_q) && (range_q >= near_q);
  assign spd_d = rej ? prev_q : spd_clamp;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    range_d = range_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    acc_d   = acc_q;
    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          st_d  = S_DIV;
          cnt_d = '0;
          rem_d = '0;
          dvd_d = s_tuser ? fscale_q : lscale_q;
        end
      end
      S_DIV: begin
        rem_d = ge ? trial_sub[HgtW-1:0] : trial[HgtW-1:0];
        dvd_d = {dvd_q[ScaleW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          st_d = S_PREP;
        end
      end
      S_PREP: begin
        range_d = quo_sat;
        st_d    = S_MUL;
      end
      S_MUL: begin
        acc_d   = acc_q + pp;
        mcand_d = mcand_q <<< 2;
        mplr_d  = mplr_q >> 2;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          st_d = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    // multiplier operands load on the way out of prepare
    if (st_q == S_PREP) begin
      mcand_d = {{(ProdW-DistW-1){err[DistW]}}, err};
      mplr_d  = gain_q;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      base_q   <= '0;
      gain_q   <= GainW'(3277);
      lim_q    <= LimW'(1106);
      jump_q   <= DistW'(307);
      near_q   <= DistW'(410);
      fscale_q <= ScaleW'(9011);
      lscale_q <= ScaleW'(18022);
      accr_q   <= '0;
      prev_q   <= '0;
      mval_q   <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE_SPEED:  base_q   <= cfg_wdata_i[SpeedW-1:0];
          REG_SPEED_GAIN:  gain_q   <= cfg_wdata_i[GainW-1:0];
          REG_SPEED_LIMIT: lim_q    <= cfg_wdata_i[LimW-1:0];
          REG_JUMP_LIMIT:  jump_q   <= cfg_wdata_i[DistW-1:0];
          REG_NEAR_LIMIT:  near_q   <= cfg_wdata_i[DistW-1:0];
          REG_FOUND_SCALE: fscale_q <= cfg_wdata_i[ScaleW-1:0];
          REG_LOST_SCALE:  lscale_q <= cfg_wdata_i[ScaleW-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        prev_q <= spd_d;
        if (!rej) begin
          accr_q <= range_q;
        end
        mval_q <= 1'b1;
      end else if (m_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    range_q <= range_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    acc_q   <= acc_d;
    if (in_fire) begin
      tgt_q <= s_tdata[DistW-1:0];
      hgt_q <= s_tdata[DistW+HgtW-1:DistW];
    end
    if (commit) begin
      mspd_q <= spd_d;
      mrej_q <= rej;
      mrng_q <= range_q;
    end
  end

  // a held-over speed always matches the stored previous speed
  a_rej_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mval_q && mrej_q) |-> (mspd_q == prev_q))
    else $error("rejected beat speed differs from previous speed");

  // a fresh speed stays inside the clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mval_q && !mrej_q) |->
      ($signed({{(24-SpeedW){mspd_q[SpeedW-1]}}, mspd_q}) <= lim_pos &&
       $signed({{(24-SpeedW){mspd_q[SpeedW-1]}}, mspd_q}) >= lim_neg))
    else $error("speed outside clamp");

  // accepted range moves only on a commit
  a_accr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(accr_q))
    else $error("accepted range changed without commit");

  // the iteration counter stays within the divider length
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (cnt_q <= DivLast))
    else $error("divider counter overran");

endmodule

`default_nettype wire

### verif/speed_command_checker.sv
`timescale 1ns / 1ps
// speed_command_checker: predicts each speed command of the range following
// speed regulator from the frame and register channels and compares it
// depends on rfsr_pkg for field widths and register indexes

module speed_command_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  // [15:0] target_distance, [27:16] pixel_height, [31:28] zero
  input  wire logic [rfsr_pkg::InDataW-1:0]  s_tdata,
  // [0] marker_found
  input  wire logic                          s_tuser,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  // [13:0] speed, [29:14] range, [31:30] zero
  input  wire logic [rfsr_pkg::OutDataW-1:0] m_tdata,
  // [0] rejected
  input  wire logic                          m_tuser,
  input  wire logic                          cfg_we_i,
  input  wire logic [rfsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rfsr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                                 mismatches,
  output int                                 outstanding
);
  import rfsr_pkg::*;

  localparam longint MaxRange = 65535;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic              rejected;
    logic [DistW-1:0]  est_range;
  } speed_cmd_t;

  longint base_speed, speed_gain, speed_limit, jump_limit, near_limit;
  longint found_scale, lost_scale;
  longint held_range, held_speed;
  speed_cmd_t commands_due[$];
  speed_cmd_t due;

  function automatic speed_cmd_t command_for_frame(input logic [DistW-1:0] target,
                                                   input logic [HgtW-1:0]  height,
                                                   input logic             found);
    longint     scale, est, vel;
    logic       rejected;
    speed_cmd_t cmd;
    scale = found ? found_scale : lost_scale;
    if (height == '0) begin
      est = MaxRange;
    end else begin
      est = scale / longint'(height);
      if (est > MaxRange) est = MaxRange;
    end
    // arithmetic shift floors the scaled product toward minus infinity
    vel = ((speed_gain * (est - longint'(target))) >>> 10) + base_speed;
    if (vel > speed_limit) vel = speed_limit;
    else if (vel < -speed_limit) vel = -speed_limit;
    rejected = (est - held_range >= jump_limit) && (est >= near_limit);
    if (rejected) vel = held_speed;
    else held_range = est;
    held_speed = vel;
    cmd.speed = vel[SpeedW-1:0];
    cmd.rejected = rejected;
    cmd.est_range = est[DistW-1:0];
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed = 0;
      speed_gain = 3277;
      speed_limit = 1106;
      jump_limit = 307;
      near_limit = 410;
      found_scale = 9011;
      lost_scale = 18022;
      held_range = 0;
      held_speed = 0;
      commands_due.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      // compare first: a frame taken on this edge cannot have its command out yet
      if (m_tvalid && m_tready) begin
        if (commands_due.size() == 0) begin
          $error("command beat with no frame waiting: tdata %h tuser %b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          due = commands_due.pop_front();
          if (m_tdata[SpeedW-1:0] !== due.speed) begin
            $error("speed: expected %0d, got %0d", $signed(due.speed),
                   $signed(m_tdata[SpeedW-1:0]));
            mismatches++;
          end
          if (m_tuser !== due.rejected) begin
            $error("rejected: expected %0d, got %0d", due.rejected, m_tuser);
            mismatches++;
          end
          if (m_tdata[SpeedW+DistW-1:SpeedW] !== due.est_range) begin
            $error("range: expected %0d, got %0d", due.est_range,
                   m_tdata[SpeedW+DistW-1:SpeedW]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        commands_due.push_back(command_for_frame(s_tdata[DistW-1:0],
                                                 s_tdata[DistW+HgtW-1:DistW], s_tuser));
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_BASE_SPEED:  base_speed = longint'($signed(cfg_wdata_i[SpeedW-1:0]));
          REG_SPEED_GAIN:  speed_gain = longint'(cfg_wdata_i[GainW-1:0]);
          REG_SPEED_LIMIT: speed_limit = longint'(cfg_wdata_i[LimW-1:0]);
          REG_JUMP_LIMIT:  jump_limit = longint'(cfg_wdata_i[DistW-1:0]);
          REG_NEAR_LIMIT:  near_limit = longint'(cfg_wdata_i[DistW-1:0]);
          REG_FOUND_SCALE: found_scale = longint'(cfg_wdata_i[ScaleW-1:0]);
          REG_LOST_SCALE:  lost_scale = longint'(cfg_wdata_i[ScaleW-1:0]);
          default: ;
        endcase
      end
      outstanding = commands_due.size();
    end
  end

endmodule

### verif/tb_range_following_speed_regulator.sv
`timescale 1ns / 1ps
// tb_range_following_speed_regulator: drives camera frames and register settings
// into the regulator with random stalls on both channels and gives the verdict
// depends on rfsr_pkg, range_following_speed_regulator and speed_command_checker

module tb_range_following_speed_regulator;
  import rfsr_pkg::*;

  localparam int StallLimit     = 2000;
  localparam int DrainCycles    = 40;
  localparam int RandomPhases   = 10;
  localparam int FramesPerPhase = 125;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int stall_left = 0;
  int walk_height;
  bit calm = 1'b0;

  range_following_speed_regulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  speed_command_checker cmd_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // command side back-pressure in bursts
  always @(negedge clk_i) begin
    if (calm) begin
      m_tready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_frame(input logic [DistW-1:0] target, input logic [HgtW-1:0] height,
                            input logic found);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata = {4'b0, height, target};
    s_tuser = found;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [SpeedW-1:0] base, input logic [GainW-1:0] gain,
                          input logic [LimW-1:0] lim, input logic [DistW-1:0] jump,
                          input logic [DistW-1:0] near, input logic [ScaleW-1:0] fscale,
                          input logic [ScaleW-1:0] lscale);
    // registers move only with the datapath empty
    s_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk_i);
    write_reg(REG_BASE_SPEED, CfgDataW'(base));
    write_reg(REG_SPEED_GAIN, CfgDataW'(gain));
    write_reg(REG_SPEED_LIMIT, CfgDataW'(lim));
    write_reg(REG_JUMP_LIMIT, CfgDataW'(jump));
    write_reg(REG_NEAR_LIMIT, CfgDataW'(near));
    write_reg(REG_FOUND_SCALE, CfgDataW'(fscale));
    write_reg(REG_LOST_SCALE, CfgDataW'(lscale));
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] maybe_extreme(input logic [CfgDataW-1:0] lo_val,
                                                        input logic [CfgDataW-1:0] hi_val,
                                                        input logic [CfgDataW-1:0] typical);
    case ($urandom_range(0, 9))
      0: return lo_val;
      1: return hi_val;
      default: return typical;
    endcase
  endfunction

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults: zero height, tiny and huge ranges, clamps, jumps around the limit
    push_frame(16'd0, 12'd0, 1'b1);
    push_frame(16'hffff, 12'd0, 1'b0);
    push_frame(16'd0, 12'hfff, 1'b1);
    push_frame(16'hffff, 12'hfff, 1'b0);
    push_frame(16'd0, 12'd1, 1'b0);
    push_frame(16'd512, 12'd30, 1'b1);
    push_frame(16'd1024, 12'd20, 1'b1);
    push_frame(16'd1024, 12'd12, 1'b1);
    push_frame(16'd1024, 12'd8, 1'b1);
    push_frame(16'd2048, 12'd6, 1'b0);
    push_frame(16'd0, 12'hfff, 1'b0);
    push_frame(16'haaaa, 12'h555, 1'b1);
    push_frame(16'h5555, 12'haaa, 1'b0);

    // every register at its top value: quotient overflow, full-scale clamps
    set_regs(14'h1fff, 16'hffff, 13'h1fff, 16'hffff, 16'hffff, 20'hfffff, 20'hfffff);
    push_frame(16'd0, 12'd1, 1'b1);
    push_frame(16'hffff, 12'd0, 1'b0);
    push_frame(16'hffff, 12'hfff, 1'b1);
    push_frame(16'd0, 12'd16, 1'b0);

    // every register at its bottom value: zero limit forces zero speed
    set_regs(14'h2000, '0, '0, '0, '0, '0, '0);
    push_frame(16'd0, 12'd5, 1'b1);
    push_frame(16'hffff, 12'd0, 1'b0);
    push_frame(16'd0, 12'hfff, 1'b0);

    // most negative base speed against the widest clamp
    set_regs(14'h2000, '0, 13'h1fff, '0, '0, '0, '0);
    push_frame(16'd100, 12'd7, 1'b1);
    push_frame(16'd0, 12'd0, 1'b1);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      calm = (ph == RandomPhases - 1) || ($urandom_range(0, 4) == 0);
      set_regs(SpeedW'(maybe_extreme(CfgDataW'(14'h2000), CfgDataW'(14'h1fff),
                                     CfgDataW'(14'($urandom_range(0, 1600) - 800)))),
               GainW'(maybe_extreme('0, CfgDataW'(16'hffff),
                                    CfgDataW'($urandom_range(0, 16000)))),
               LimW'(maybe_extreme('0, CfgDataW'(13'h1fff),
                                   CfgDataW'($urandom_range(1, 4000)))),
               DistW'(maybe_extreme('0, CfgDataW'(16'hffff),
                                    CfgDataW'($urandom_range(50, 2000)))),
               DistW'(maybe_extreme('0, CfgDataW'(16'hffff),
                                    CfgDataW'($urandom_range(0, 3000)))),
               ScaleW'(maybe_extreme('0, CfgDataW'(20'hfffff),
                                     CfgDataW'($urandom_range(1000, 200000)))),
               ScaleW'(maybe_extreme('0, CfgDataW'(20'hfffff),
                                     CfgDataW'($urandom_range(1000, 200000)))));
      walk_height = $urandom_range(8, 400);
      for (int n = 0; n < FramesPerPhase; n++) begin
        case ($urandom_range(0, 9))
          0: push_frame(16'($urandom), 12'($urandom), 1'($urandom));
          1: push_frame(16'($urandom), $urandom_range(0, 1) ? 12'hfff : 12'($urandom_range(0, 2)),
                        1'($urandom));
          default: begin
            // marker height drifts as the leader moves, with the odd lost frame
            walk_height = walk_height + int'($urandom_range(0, 16)) - 8;
            if (walk_height < 1) walk_height = 1;
            if (walk_height > 4095) walk_height = 4095;
            push_frame(16'($urandom_range(0, 4095)), 12'(walk_height),
                       $urandom_range(0, 7) != 0);
          end
        endcase
      end
    end

    s_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
